### rtl/mcafm_pkg.sv
// ----------------------------------------------------------------------------
// Multi-context adaptive frequency model: shared definitions
// Sizes, word formats, datapath actions and the saturating helper used by the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
package mcafm_pkg;

  // Model size.
  localparam int ALPHABET = 256;
  localparam int ROWS     = 16;

  // Field and storage widths.
  localparam int ROW_FW  = 4;    // context_row field
  localparam int SYM_FW  = 9;    // symbol_index field
  localparam int RES_FW  = 15;   // result bound fields
  localparam int LIM_W   = 14;   // limit registers
  localparam int CFG_IW  = 2;    // configuration register index
  localparam int CNT_W   = 15;   // stored counts
  localparam int IDX_W   = $clog2(ALPHABET + 1);
  localparam int RA_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ACC_W   = CNT_W + IDX_W;
  localparam int MEM_DEPTH = 2 ** (RA_W + IDX_W);

  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ALPHABET);
  localparam logic [RA_W-1:0]  ROW_LAST = RA_W'(ROWS - 1);

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_LIMIT_ROW_ZERO   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_LIMIT_OTHER_ROWS = 2'd1;
  localparam logic [CFG_IW-1:0] REG_BIG_STEP_MODE    = 2'd2;

  typedef struct packed {
    logic [ROW_FW-1:0] context_row;
    logic [SYM_FW-1:0] symbol_index;
  } sym_word_t;

  typedef struct packed {
    logic [RES_FW-1:0] cum_low;
    logic [RES_FW-1:0] cum_high;
    logic [RES_FW-1:0] row_total;
    logic              did_rescale;
  } res_word_t;

  // One datapath action per microcode step.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLR,
    ACT_ACCEPT,
    ACT_RD_TOT,
    ACT_RD_LO,
    ACT_RD_HI,
    ACT_CAP_HI,
    ACT_OUT,
    ACT_RESC_RD,
    ACT_RESC,
    ACT_CNT_RD,
    ACT_CNT_WR,
    ACT_CUM
  } act_t;

  // Datapath control taken from the current control word.
  typedef struct packed {
    logic in_rdy;
    act_t act;
  } dp_ctl_t;

  // Status fed back to the sequencer for its conditional jumps.
  typedef struct packed {
    logic in_acc;
    logic out_busy;
    logic skip;
    logic no_resc;
    logic more;
  } sts_t;

  // Clamp a widened sum to the largest storable count.
  function automatic logic [CNT_W-1:0] sat_cnt(input logic [ACC_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v > ACC_W'(CNT_MAX)) ? CNT_MAX : v[CNT_W-1:0];
    return r;
  endfunction

endpackage

### rtl/mcafm_seq.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter and read-only control store; each step selects one datapath
// action and an optional conditional jump.
// ----------------------------------------------------------------------------
module mcafm_seq (
  input  logic             clk,
  input  logic             rst,
  input  mcafm_pkg::sts_t  sts,
  output mcafm_pkg::dp_ctl_t ctl
);

  typedef enum logic [3:0] {
    U_CLR,
    U_IDLE,
    U_RD_TOT,
    U_RD_LO,
    U_RD_HI,
    U_CAP_HI,
    U_OUT,
    U_CHK,
    U_DEC,
    U_RESC_RD,
    U_RESC,
    U_CNT_RD,
    U_CNT_WR,
    U_CUM,
    U_DONE
  } step_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_OUT_BUSY,
    C_SKIP,
    C_NO_RESC,
    C_MORE
  } cond_t;

  typedef struct packed {
    logic           in_rdy;
    mcafm_pkg::act_t act;
    cond_t          cond;
    step_t          target;
  } uword_t;

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   take;

  // Control store.
  always_comb begin
    case (pc)
      U_CLR:     uw = '{1'b0, mcafm_pkg::ACT_CLR,     C_MORE,     U_CLR};
      U_IDLE:    uw = '{1'b1, mcafm_pkg::ACT_ACCEPT,  C_NO_INPUT, U_IDLE};
      U_RD_TOT:  uw = '{1'b0, mcafm_pkg::ACT_RD_TOT,  C_NEVER,    U_IDLE};
      U_RD_LO:   uw = '{1'b0, mcafm_pkg::ACT_RD_LO,   C_NEVER,    U_IDLE};
      U_RD_HI:   uw = '{1'b0, mcafm_pkg::ACT_RD_HI,   C_NEVER,    U_IDLE};
      U_CAP_HI:  uw = '{1'b0, mcafm_pkg::ACT_CAP_HI,  C_NEVER,    U_IDLE};
      U_OUT:     uw = '{1'b0, mcafm_pkg::ACT_OUT,     C_OUT_BUSY, U_OUT};
      U_CHK:     uw = '{1'b0, mcafm_pkg::ACT_NONE,    C_SKIP,     U_IDLE};
      U_DEC:     uw = '{1'b0, mcafm_pkg::ACT_NONE,    C_NO_RESC,  U_CNT_RD};
      U_RESC_RD: uw = '{1'b0, mcafm_pkg::ACT_RESC_RD, C_NEVER,    U_IDLE};
      U_RESC:    uw = '{1'b0, mcafm_pkg::ACT_RESC,    C_MORE,     U_RESC};
      U_CNT_RD:  uw = '{1'b0, mcafm_pkg::ACT_CNT_RD,  C_NEVER,    U_IDLE};
      U_CNT_WR:  uw = '{1'b0, mcafm_pkg::ACT_CNT_WR,  C_NEVER,    U_IDLE};
      U_CUM:     uw = '{1'b0, mcafm_pkg::ACT_CUM,     C_MORE,     U_CUM};
      U_DONE:    uw = '{1'b0, mcafm_pkg::ACT_NONE,    C_ALWAYS,   U_IDLE};
      default:   uw = '{1'b0, mcafm_pkg::ACT_NONE,    C_ALWAYS,   U_IDLE};
    endcase
  end

  always_comb begin
    case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = !sts.in_acc;
      C_OUT_BUSY: take = sts.out_busy;
      C_SKIP:     take = sts.skip;
      C_NO_RESC:  take = sts.no_resc;
      C_MORE:     take = sts.more;
      default:    take = 1'b1;
    endcase
    pc_next = take ? uw.target : step_t'(pc + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= U_CLR;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctl.in_rdy = uw.in_rdy;
  assign ctl.act    = uw.act;

endmodule

### rtl/multi_context_adaptive_frequency_model_top.sv
// ----------------------------------------------------------------------------
// Multi-context adaptive frequency model
// Per-context symbol frequency tables for an arithmetic coder, run by a
// microcoded sequencer over two single-port-read, single-port-write memories.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Word / fields
//  -------  ---------------------  --------------------------------------------
//  sym      sym_valid, sym_ready   sym_word: context_row, symbol_index
//  res      res_valid, res_ready   res_word: cum_low, cum_high, row_total,
//                                  did_rescale
//  cfg      cfg_valid, cfg_ready   cfg_index, cfg_data (always ready)
//
//  One word is taken at a time: the next is not accepted before the table
//  update of the last is done. The update raises the cumulative entries
//  below the symbol index, and a word that halves its row first walks over
//  the whole row.
//  The update time comes from the single write port on each table memory:
//  one entry is read, modified and written back per cycle.
//  A symbol outside the alphabet skips the table update.
//  After reset a clearing pass over ROWS * (ALPHABET + 1) = 4112 entries
//  loads the reset counts before the first word is taken; cfg writes are
//  taken throughout.
//  The result sits in an output register, so a stalled res channel only
//  delays the next result, not the table update already under way.
//
module multi_context_adaptive_frequency_model_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sym_valid,
  output logic                         sym_ready,
  input  mcafm_pkg::sym_word_t         sym_word,
  output logic                         res_valid,
  input  logic                         res_ready,
  output mcafm_pkg::res_word_t         res_word,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mcafm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mcafm_pkg::LIM_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [mcafm_pkg::LIM_W-1:0] limit_row_zero;
  logic [mcafm_pkg::LIM_W-1:0] limit_other_rows;
  logic                        big_step_mode;

  // Sequencer interface.
  mcafm_pkg::dp_ctl_t ctl;
  mcafm_pkg::sts_t    sts;
  logic               in_acc;
  logic               out_busy;

  // Latched word and working registers.
  logic [mcafm_pkg::ROW_FW-1:0] row_in;
  logic [mcafm_pkg::SYM_FW-1:0] sym;
  logic [mcafm_pkg::RA_W-1:0]   mrow;
  logic [mcafm_pkg::RA_W-1:0]   mrow_next;
  logic [mcafm_pkg::IDX_W-1:0]  widx;
  logic [mcafm_pkg::IDX_W-1:0]  widx_next;
  logic [mcafm_pkg::ACC_W-1:0]  acc;
  logic [mcafm_pkg::ACC_W-1:0]  acc_next;
  logic [mcafm_pkg::CNT_W-1:0]  total;
  logic [mcafm_pkg::CNT_W-1:0]  lo;
  logic [mcafm_pkg::CNT_W-1:0]  hi;

  logic [mcafm_pkg::IDX_W-1:0]  sidx;
  logic                         row_ok;
  logic                         sym_ok;
  logic                         resc_now;
  logic [mcafm_pkg::CNT_W-1:0]  limit_sel;
  logic [mcafm_pkg::ACC_W-1:0]  step_v;
  logic [mcafm_pkg::CNT_W:0]    cnt_inc;
  logic [mcafm_pkg::CNT_W-1:0]  half;
  logic                         more;

  // Table memories: symbol counts and cumulative counts, addressed {row, index}.
  localparam int AW = mcafm_pkg::RA_W + mcafm_pkg::IDX_W;

  logic [mcafm_pkg::CNT_W-1:0] cnt_mem [mcafm_pkg::MEM_DEPTH];
  logic [mcafm_pkg::CNT_W-1:0] cum_mem [mcafm_pkg::MEM_DEPTH];
  logic                        cnt_we;
  logic                        cum_we;
  logic [AW-1:0]               cnt_waddr;
  logic [AW-1:0]               cum_waddr;
  logic [AW-1:0]               cnt_raddr;
  logic [AW-1:0]               cum_raddr;
  logic [mcafm_pkg::CNT_W-1:0] cnt_wdata;
  logic [mcafm_pkg::CNT_W-1:0] cum_wdata;
  logic [mcafm_pkg::CNT_W-1:0] cnt_rdata;
  logic [mcafm_pkg::CNT_W-1:0] cum_rdata;

  mcafm_seq u_seq (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  assign sym_ready = ctl.in_rdy;
  assign cfg_ready = 1'b1;
  assign in_acc    = sym_valid && sym_ready;
  assign out_busy  = res_valid && !res_ready;

  // Range checks on the latched word, and the halving decision taken from
  // the row total as it stood before the update.
  assign sidx      = mcafm_pkg::IDX_W'(sym);
  assign row_ok    = int'(row_in) < mcafm_pkg::ROWS;
  assign sym_ok    = (sym != '0) && (int'(sym) <= mcafm_pkg::ALPHABET);
  assign limit_sel = (row_in == '0) ? mcafm_pkg::CNT_W'(limit_row_zero)
                                    : mcafm_pkg::CNT_W'(limit_other_rows);
  assign resc_now  = total >= limit_sel;

  assign step_v  = big_step_mode ? mcafm_pkg::ACC_W'(mcafm_pkg::ALPHABET)
                                 : mcafm_pkg::ACC_W'(1);
  // Halving rounds up: (count + 1) / 2.
  assign cnt_inc = {1'b0, cnt_rdata} + (mcafm_pkg::CNT_W + 1)'(1);
  assign half    = cnt_inc[mcafm_pkg::CNT_W:1];

  assign sts.in_acc   = in_acc;
  assign sts.out_busy = out_busy;
  assign sts.skip     = !(row_ok && sym_ok);
  assign sts.no_resc  = !resc_now;
  assign sts.more     = more;

  // Datapath decode of the current action.
  always_comb begin
    cnt_we    = 1'b0;
    cum_we    = 1'b0;
    cnt_waddr = {mrow, widx};
    cum_waddr = {mrow, widx};
    cnt_raddr = {mrow, widx};
    cum_raddr = {mrow, widx};
    cnt_wdata = '0;
    cum_wdata = '0;
    widx_next = widx;
    mrow_next = mrow;
    acc_next  = acc;
    more      = 1'b0;
    case (ctl.act)
      mcafm_pkg::ACT_CLR: begin
        // Reset contents: count one per symbol (none at index zero),
        // cumulative entry i equal to ALPHABET - i.
        cnt_we    = 1'b1;
        cum_we    = 1'b1;
        cnt_wdata = (widx == '0) ? '0 : mcafm_pkg::CNT_W'(1);
        cum_wdata = mcafm_pkg::CNT_W'(mcafm_pkg::ALPHABET - int'(widx));
        more      = !((mrow == mcafm_pkg::ROW_LAST) && (widx == mcafm_pkg::IDX_LAST));
        if (widx == mcafm_pkg::IDX_LAST) begin
          widx_next = '0;
          mrow_next = mrow + mcafm_pkg::RA_W'(1);
        end else begin
          widx_next = widx + mcafm_pkg::IDX_W'(1);
        end
      end
      mcafm_pkg::ACT_ACCEPT: begin
        if (in_acc) begin
          mrow_next = mcafm_pkg::RA_W'(sym_word.context_row);
        end
      end
      mcafm_pkg::ACT_RD_TOT: begin
        cum_raddr = {mrow, {mcafm_pkg::IDX_W{1'b0}}};
      end
      mcafm_pkg::ACT_RD_LO: begin
        cum_raddr = {mrow, sidx};
      end
      mcafm_pkg::ACT_RD_HI: begin
        cum_raddr = {mrow, sidx - mcafm_pkg::IDX_W'(1)};
      end
      mcafm_pkg::ACT_RESC_RD: begin
        cnt_raddr = {mrow, mcafm_pkg::IDX_LAST};
        widx_next = mcafm_pkg::IDX_LAST;
        acc_next  = '0;
      end
      mcafm_pkg::ACT_RESC: begin
        // Walk from the top index down: the cumulative entry takes the sum of
        // the halved counts above it, read one entry ahead.
        cnt_we    = 1'b1;
        cum_we    = 1'b1;
        cnt_wdata = half;
        cum_wdata = mcafm_pkg::sat_cnt(acc);
        acc_next  = acc + mcafm_pkg::ACC_W'(half);
        cnt_raddr = {mrow, widx - mcafm_pkg::IDX_W'(1)};
        widx_next = widx - mcafm_pkg::IDX_W'(1);
        more      = widx != '0;
      end
      mcafm_pkg::ACT_CNT_RD: begin
        cnt_raddr = {mrow, sidx};
      end
      mcafm_pkg::ACT_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = {mrow, sidx};
        cnt_wdata = mcafm_pkg::sat_cnt(mcafm_pkg::ACC_W'(cnt_rdata) + step_v);
        cum_raddr = {mrow, {mcafm_pkg::IDX_W{1'b0}}};
        widx_next = '0;
      end
      mcafm_pkg::ACT_CUM: begin
        // Raise cumulative entries 0 .. s-1, one per cycle.
        cum_we    = 1'b1;
        cum_wdata = mcafm_pkg::sat_cnt(mcafm_pkg::ACC_W'(cum_rdata) + step_v);
        cum_raddr = {mrow, widx + mcafm_pkg::IDX_W'(1)};
        widx_next = widx + mcafm_pkg::IDX_W'(1);
        more      = (widx + mcafm_pkg::IDX_W'(1)) != sidx;
      end
      default: begin
        more = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cum_we) begin
      cum_mem[cum_waddr] <= cum_wdata;
    end
    cum_rdata <= cum_mem[cum_raddr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_row_zero   <= mcafm_pkg::LIM_W'(16383);
      limit_other_rows <= mcafm_pkg::LIM_W'(400);
      big_step_mode    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mcafm_pkg::REG_LIMIT_ROW_ZERO:   limit_row_zero   <= cfg_data;
        mcafm_pkg::REG_LIMIT_OTHER_ROWS: limit_other_rows <= cfg_data;
        mcafm_pkg::REG_BIG_STEP_MODE:    big_step_mode    <= cfg_data[0];
        default: begin
          big_step_mode <= big_step_mode;
        end
      endcase
    end
  end

  // Walk counters; the clearing pass starts from row zero, index zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      mrow <= '0;
      widx <= '0;
    end else begin
      mrow <= mrow_next;
      widx <= widx_next;
    end
  end

  // Word latch, captured bounds and the running sum of the halving walk.
  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (ctl.act == mcafm_pkg::ACT_ACCEPT && in_acc) begin
      row_in <= sym_word.context_row;
      sym    <= sym_word.symbol_index;
    end
    if (ctl.act == mcafm_pkg::ACT_RD_LO) begin
      total <= cum_rdata;
    end
    if (ctl.act == mcafm_pkg::ACT_RD_HI) begin
      lo <= cum_rdata;
    end
    if (ctl.act == mcafm_pkg::ACT_CAP_HI) begin
      hi <= cum_rdata;
    end
  end

  // Output register. An unknown row reports all zeros; an unknown symbol
  // reports the row total only.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.act == mcafm_pkg::ACT_OUT && !out_busy) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.act == mcafm_pkg::ACT_OUT && !out_busy) begin
      res_word.row_total   <= row_ok ? mcafm_pkg::RES_FW'(total) : '0;
      res_word.cum_low     <= (row_ok && sym_ok) ? mcafm_pkg::RES_FW'(lo) : '0;
      res_word.cum_high    <= (row_ok && sym_ok) ? mcafm_pkg::RES_FW'(hi) : '0;
      res_word.did_rescale <= row_ok && sym_ok && resc_now;
    end
  end

endmodule

### rtl/mcafm_chk.sv
// ----------------------------------------------------------------------------
// Port checker for the adaptive frequency model
// Watches the top level's channels for ordering and value properties.
// ----------------------------------------------------------------------------
module mcafm_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 sym_valid,
  input logic                 sym_ready,
  input logic                 res_valid,
  input logic                 res_ready,
  input mcafm_pkg::res_word_t res_word
);

  // A result waiting on the consumer holds its word.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_word))
    else $error("result word changed while stalled");

  // Interval bounds nest inside the row total.
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_word.cum_high >= res_word.cum_low) &&
                  (res_word.row_total >= res_word.cum_high))
    else $error("result bounds out of order");

  // One word at a time: the update keeps the input closed after acceptance.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    sym_valid && sym_ready |=> !sym_ready)
    else $error("input reopened straight after a word was taken");

  // No word is taken straight after reset, while the tables are being cleared, and no result is shown.
  a_clear: assert property (@(posedge clk)
    rst |=> !sym_ready && !res_valid)
    else $error("block active straight after reset");

endmodule

bind multi_context_adaptive_frequency_model_top mcafm_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .sym_valid (sym_valid),
  .sym_ready (sym_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_word  (res_word)
);

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-context adaptive frequency model: block-level testbench
// Drives symbol words into the model, predicts every result word from a
// private copy of the frequency tables and checks the bounds, the row total
// and the rescale flag of each returned word in order. Runs a directed
// opening, limit and step-mode extremes, four idling phases of random
// traffic and a long result hold-off.
// ----------------------------------------------------------------------------
module tb;

  // Register index with no register behind it; a write there must be ignored.
  localparam logic [mcafm_pkg::CFG_IW-1:0] REG_UNUSED = 2'd3;

  // Long enough to cover any update still running, a rescale included,
  // once the last result word has left the block.
  localparam int SETTLE_CYCLES = 600;
  // Set well above the slowest legal run.
  localparam int LIMIT_CYCLES  = 4_000_000;
  localparam int PHASE_WORDS   = 275;
  localparam int HOLD_CYCLES   = 3000;

  logic                           clk;
  logic                           rst;
  logic                           sym_valid;
  logic                           sym_ready;
  mcafm_pkg::sym_word_t           sym_word;
  logic                           res_valid;
  logic                           res_ready;
  mcafm_pkg::res_word_t           res_word;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [mcafm_pkg::CFG_IW-1:0]   cfg_index;
  logic [mcafm_pkg::LIM_W-1:0]    cfg_data;

  multi_context_adaptive_frequency_model_top u_top (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_ready (sym_ready),
    .sym_word  (sym_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predicted state: the counts and cumulative tables of every row, and the
  // three registers as the block should hold them.
  // --------------------------------------------------------------------------
  logic [mcafm_pkg::CNT_W-1:0] freq_count [mcafm_pkg::ROWS][mcafm_pkg::ALPHABET+1];
  logic [mcafm_pkg::CNT_W-1:0] freq_cum   [mcafm_pkg::ROWS][mcafm_pkg::ALPHABET+1];
  logic [mcafm_pkg::LIM_W-1:0] limit_zero;
  logic [mcafm_pkg::LIM_W-1:0] limit_other;
  logic                        big_step;

  // Bounds predicted for words already taken, oldest first.
  mcafm_pkg::res_word_t pending_bounds [$];
  mcafm_pkg::res_word_t oldest_bounds;

  int errors;
  int words_sent;
  int words_out_of_range;
  int results_seen;
  int rescales_seen;
  int cycle_count;

  // Idling knobs, in percent per cycle, and the hold-off request.
  int idle_pct;
  int stall_pct;
  int hold_len;
  int hold_left;
  int hot_row;

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The limit also covers the clearing pass after reset.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("multi_context_adaptive_frequency_model_top test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [mcafm_pkg::CNT_W-1:0] clamp_count(input int v);
    return (v > int'(mcafm_pkg::CNT_MAX)) ? mcafm_pkg::CNT_MAX : mcafm_pkg::CNT_W'(v);
  endfunction

  function automatic void load_reset_tables();
    for (int r = 0; r < mcafm_pkg::ROWS; r++) begin
      for (int j = 0; j <= mcafm_pkg::ALPHABET; j++) begin
        freq_count[r][j] = (j == 0) ? '0 : mcafm_pkg::CNT_W'(1);
        freq_cum[r][j]   = mcafm_pkg::CNT_W'(mcafm_pkg::ALPHABET - j);
      end
    end
    limit_zero  = mcafm_pkg::LIM_W'(16383);
    limit_other = mcafm_pkg::LIM_W'(400);
    big_step    = 1'b0;
  endfunction

  // Halve every count of the row, rounding up, and rebuild the cumulative
  // table from the top symbol downwards.
  function automatic void halve_row(input int r);
    int acc;
    acc = 0;
    for (int i = mcafm_pkg::ALPHABET; i >= 0; i--) begin
      freq_count[r][i] = mcafm_pkg::CNT_W'((int'(freq_count[r][i]) + 1) >> 1);
      freq_cum[r][i]   = clamp_count(acc);
      acc += int'(freq_count[r][i]);
    end
  endfunction

  // Works out the result word for one symbol word and applies its update.
  function automatic mcafm_pkg::res_word_t code_interval(input mcafm_pkg::sym_word_t w);
    mcafm_pkg::res_word_t        r;
    int                          row;
    int                          sym;
    int                          step;
    logic [mcafm_pkg::LIM_W-1:0] lim;
    r   = '0;
    row = int'(w.context_row);
    sym = int'(w.symbol_index);
    if (row >= mcafm_pkg::ROWS) return r;
    r.row_total = freq_cum[row][0];
    if (sym == 0 || sym > mcafm_pkg::ALPHABET) return r;
    r.cum_low  = freq_cum[row][sym];
    r.cum_high = freq_cum[row][sym-1];
    lim = (row == 0) ? limit_zero : limit_other;
    if (int'(freq_cum[row][0]) >= int'(lim)) begin
      halve_row(row);
      r.did_rescale = 1'b1;
    end
    step = big_step ? mcafm_pkg::ALPHABET : 1;
    freq_count[row][sym] = clamp_count(int'(freq_count[row][sym]) + step);
    for (int j = 0; j < sym; j++)
      freq_cum[row][j] = clamp_count(int'(freq_cum[row][j]) + step);
    return r;
  endfunction

  function automatic mcafm_pkg::sym_word_t make_word(input int row, input int sym);
    mcafm_pkg::sym_word_t w;
    w.context_row  = mcafm_pkg::ROW_FW'(row);
    w.symbol_index = mcafm_pkg::SYM_FW'(sym);
    return w;
  endfunction

  // Random traffic: mostly valid symbols, concentrated on row zero and one
  // hot row so that rescales come round often, with a share of symbols
  // outside the alphabet and words for any row.
  function automatic mcafm_pkg::sym_word_t random_word();
    int pick;
    int row;
    int sym;
    pick = $urandom_range(99);
    if (pick < 35)      row = 0;
    else if (pick < 75) row = hot_row;
    else                row = $urandom_range(mcafm_pkg::ROWS - 1);
    pick = $urandom_range(99);
    if (pick < 8)
      sym = ($urandom_range(1) == 0) ? 0 : $urandom_range(mcafm_pkg::ALPHABET + 1, 511);
    else if (pick < 50) sym = $urandom_range(1, 32);
    else if (pick < 88) sym = $urandom_range(1, mcafm_pkg::ALPHABET);
    else if (pick < 94) sym = mcafm_pkg::ALPHABET;
    else                sym = ($urandom_range(1) == 0) ? 1 : mcafm_pkg::ALPHABET - 1;
    return make_word(row, sym);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: ready with random stalls, and a hold-off counted here.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every result word is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_bounds.size() == 0) begin
        $error("result word with no prediction waiting: %p", res_word);
        errors++;
      end else begin
        oldest_bounds = pending_bounds.pop_front();
        results_seen++;
        if (res_word.did_rescale) rescales_seen++;
        if (res_word.cum_low !== oldest_bounds.cum_low) begin
          $error("cum_low: expected %0d, actual %0d", oldest_bounds.cum_low,
                 res_word.cum_low);
          errors++;
        end
        if (res_word.cum_high !== oldest_bounds.cum_high) begin
          $error("cum_high: expected %0d, actual %0d", oldest_bounds.cum_high,
                 res_word.cum_high);
          errors++;
        end
        if (res_word.row_total !== oldest_bounds.row_total) begin
          $error("row_total: expected %0d, actual %0d", oldest_bounds.row_total,
                 res_word.row_total);
          errors++;
        end
        if (res_word.did_rescale !== oldest_bounds.did_rescale) begin
          $error("did_rescale: expected %0d, actual %0d", oldest_bounds.did_rescale,
                 res_word.did_rescale);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sending side
  // --------------------------------------------------------------------------

  // Offers one symbol word after a random gap and predicts its result at the
  // edge where it is taken. Valid stays high between back-to-back words.
  task automatic send_symbol(input mcafm_pkg::sym_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      sym_valid <= 1'b0;
      @(negedge clk);
    end
    sym_valid <= 1'b1;
    sym_word  <= w;
    do @(posedge clk); while (!sym_ready);
    pending_bounds.push_back(code_interval(w));
    words_sent++;
    if (w.symbol_index == 0 || int'(w.symbol_index) > mcafm_pkg::ALPHABET)
      words_out_of_range++;
  endtask

  // Lets the block go idle: no word offered, every result back, and time for
  // the table update that follows the last result to finish.
  task automatic settle_block();
    @(negedge clk);
    sym_valid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; only called while the block is idle.
  task automatic write_reg(input logic [mcafm_pkg::CFG_IW-1:0] idx,
                           input logic [mcafm_pkg::LIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mcafm_pkg::REG_LIMIT_ROW_ZERO:   limit_zero  = data;
      mcafm_pkg::REG_LIMIT_OTHER_ROWS: limit_other = data;
      mcafm_pkg::REG_BIG_STEP_MODE:    big_step    = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_regs(input int lim0, input int lim1, input int mode);
    write_reg(mcafm_pkg::REG_LIMIT_ROW_ZERO,   mcafm_pkg::LIM_W'(lim0));
    write_reg(mcafm_pkg::REG_LIMIT_OTHER_ROWS, mcafm_pkg::LIM_W'(lim1));
    write_reg(mcafm_pkg::REG_BIG_STEP_MODE,    mcafm_pkg::LIM_W'(mode));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset tables and reset registers: both ends of the alphabet, both ends of
  // the row range, and symbols outside the alphabet (zero, just above it and
  // the all-ones field), which must leave the tables untouched.
  task automatic test_reset_tables();
    idle_pct  = 0;
    stall_pct = 0;
    send_symbol(make_word(0, 1));
    send_symbol(make_word(0, mcafm_pkg::ALPHABET));
    send_symbol(make_word(mcafm_pkg::ROWS - 1, mcafm_pkg::ALPHABET));
    send_symbol(make_word(mcafm_pkg::ROWS - 1, 1));
    send_symbol(make_word(5, 128));
    send_symbol(make_word(10, mcafm_pkg::ALPHABET - 1));
    send_symbol(make_word(0, 0));
    send_symbol(make_word(3, mcafm_pkg::ALPHABET + 1));
    send_symbol(make_word(12, 511));
    send_symbol(make_word(0, mcafm_pkg::ALPHABET));
    settle_block();
  endtask

  // Limit extremes and both step modes. A limit of zero makes every word of
  // that row rescale; a limit of one does the same for the other rows.
  task automatic test_limit_extremes();
    write_reg(mcafm_pkg::REG_LIMIT_ROW_ZERO, '0);
    send_symbol(make_word(0, 3));
    send_symbol(make_word(0, 3));
    send_symbol(make_word(0, mcafm_pkg::ALPHABET));
    settle_block();
    write_reg(mcafm_pkg::REG_LIMIT_OTHER_ROWS, mcafm_pkg::LIM_W'(1));
    write_reg(mcafm_pkg::REG_BIG_STEP_MODE, mcafm_pkg::LIM_W'(1));
    send_symbol(make_word(7, 200));
    send_symbol(make_word(7, 1));
    send_symbol(make_word(0, mcafm_pkg::ALPHABET));
    settle_block();
    // A write to the unused index changes nothing.
    write_reg(REG_UNUSED, mcafm_pkg::LIM_W'(16383));
    write_all_regs(16383, 16383, 1);
    send_symbol(make_word(7, mcafm_pkg::ALPHABET));
    send_symbol(make_word(mcafm_pkg::ROWS - 1, 2));
    send_symbol(make_word(0, 1));
    settle_block();
  endtask

  // Random traffic in four idling phases, each under its own register set.
  task automatic test_random_phases();
    int idle_tab  [4];
    int stall_tab [4];
    idle_tab  = '{0, 53, 0, 31};
    stall_tab = '{0, 0, 53, 31};
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_all_regs(16383, 400, 0);
        1: write_all_regs($urandom_range(1, 600), $urandom_range(1, 16383), 1);
        2: write_all_regs(16383, $urandom_range(300, 3000), 1);
        default: write_all_regs($urandom_range(0, 16383), $urandom_range(1, 1000),
                                $urandom_range(1));
      endcase
      hot_row   = $urandom_range(1, mcafm_pkg::ROWS - 1);
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      for (int k = 0; k < PHASE_WORDS; k++)
        send_symbol(random_word());
      settle_block();
    end
  endtask

  // The result side holds off for a long stretch while words keep coming, so
  // the output register fills and the block has to stall its input.
  task automatic test_result_holdoff();
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_len = HOLD_CYCLES;
    for (int k = 0; k < 24; k++)
      send_symbol(random_word());
    settle_block();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    sym_valid = 1'b0;
    sym_word  = '0;
    res_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors = 0;
    words_sent = 0;
    words_out_of_range = 0;
    results_seen = 0;
    rescales_seen = 0;
    cycle_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    hold_left = 0;
    hot_row = 1;
    load_reset_tables();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_tables();
    test_limit_extremes();
    test_random_phases();
    test_result_holdoff();

    $display("Checked %0d result words for %0d symbol words (%0d outside the alphabet),",
             results_seen, words_sent, words_out_of_range);
    $display("%0d of them rescaling, over limits 0 to 16383, both step modes and stalls.",
             rescales_seen);
    if (errors == 0) begin
      $display("multi_context_adaptive_frequency_model_top test passed");
    end else begin
      $display("multi_context_adaptive_frequency_model_top test failed");
    end
    $finish;
  end

endmodule

### multi_context_adaptive_frequency_model_top.f
rtl/mcafm_pkg.sv
rtl/mcafm_seq.sv
rtl/multi_context_adaptive_frequency_model_top.sv
rtl/mcafm_chk.sv
test/tb.sv
